/* rtl/fatdir_pkg.sv */
// ----------------------------------------------------------------------------
// fatdir_pkg
// Shared types, constants and helpers for the FAT16 root directory scanner.
// ----------------------------------------------------------------------------
package fatdir_pkg;

    // Directory entry layout
    localparam int unsigned ENTRY_BYTES = 32;
    localparam int unsigned POS_W       = $clog2(ENTRY_BYTES);

    localparam logic [POS_W-1:0] POS_FIRST   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_EXT0    = POS_W'(8);
    localparam logic [POS_W-1:0] POS_ATTR    = POS_W'(11);
    localparam logic [POS_W-1:0] POS_CLUS0   = POS_W'(26);
    localparam logic [POS_W-1:0] POS_CLUS1   = POS_W'(27);
    localparam logic [POS_W-1:0] POS_SIZE0   = POS_W'(28);
    localparam logic [POS_W-1:0] POS_LAST    = POS_W'(ENTRY_BYTES - 1);

    // Marker and attribute codes
    localparam logic [7:0] BYTE_END_MARK  = 8'h00;
    localparam logic [7:0] BYTE_DELETED   = 8'hE5;
    localparam logic [7:0] BYTE_SPACE     = 8'h20;
    localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
    localparam logic [7:0] ATTR_DIR       = 8'h10;
    localparam logic [7:0] ATTR_FILE      = 8'h20;

    // Result codes
    localparam logic       STATUS_ENTRY = 1'b0;
    localparam logic       STATUS_END   = 1'b1;
    localparam logic [1:0] KIND_DIR     = 2'd0;
    localparam logic [1:0] KIND_FILE    = 2'd1;
    localparam logic [1:0] KIND_OTHER   = 2'd2;

    // Configuration register map
    localparam int unsigned PADDR_W       = 3;
    localparam int unsigned PDATA_W       = 32;
    localparam logic [PADDR_W-3:0] REG_ROOT_ENTRY_COUNT = '0;
    localparam logic [15:0] ROOT_COUNT_RESET = 16'd512;

    // Result queue depth (two results can arrive in one cycle)
    localparam int unsigned RQ_DEPTH_DEF = 4;

    typedef struct packed {
        logic [7:0] dir_byte;
        logic       region_start;
    } dir_in_t;

    typedef struct packed {
        logic        result_status;
        logic [1:0]  entry_kind;
        logic [63:0] name_bytes;
        logic [3:0]  name_length;
        logic [23:0] ext_bytes;
        logic [1:0]  ext_length;
        logic [15:0] first_cluster;
        logic [31:0] file_size;
        logic [15:0] entry_number;
    } dir_out_t;

    // Push request from parser to result queue; push1 only with push0
    typedef struct packed {
        logic push0;
        logic push1;
    } rq_push_t;

    function automatic dir_out_t make_end(input logic [15:0] count);
        dir_out_t r;
        r              = '0;
        r.result_status = STATUS_END;
        r.entry_number  = count;
        return r;
    endfunction

    function automatic logic is_pad(input logic [7:0] b);
        return (b == BYTE_END_MARK) || (b == BYTE_SPACE);
    endfunction

endpackage

/* rtl/fat16_root_directory_scanner_core.sv */
// ----------------------------------------------------------------------------
// fat16_root_directory_scanner_core
// FAT16 root directory scanner: splits the root region into 32-byte entries
// and reports 8.3 entries plus an end-of-scan transaction.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+---------------------------
//  in       | input     | in_valid / in_stall    | dir_in_t  (byte, start)
//  out      | output    | out_valid / out_stall  | dir_out_t (one result)
//  APB      | input     | psel/penable/pready    | root_entry_count @ 0x0
//
//  Cycles: one byte transaction per clock while in_stall is low. Each byte
//  is folded into the entry stores in the cycle it is accepted; its results
//  are written into the result queue at that same accepting edge, so with
//  the queue otherwise empty a result is offered in the cycle right after
//  its last byte is taken. A byte may give two results (last entry and end
//  of scan); the queue takes both in one cycle and drains one per clock
//  while out_stall is low. in_stall rises when the queue has less than two
//  free slots; it comes from a register and does not depend on in_valid.
//  Reset: scan idle, queue empty, root_entry_count = 512.
//
module fat16_root_directory_scanner_core
    import fatdir_pkg::*;
#(
    parameter int unsigned RQ_DEPTH = RQ_DEPTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    // byte stream in
    input  logic               in_valid,
    output logic               in_stall,
    input  dir_in_t            in_data,

    // results out
    output logic               out_valid,
    input  logic               out_stall,
    output dir_out_t           out_data,

    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [15:0] count_reg, count_next;
    logic        cfg_wr;
    logic        cfg_hit;
    logic        in_fire;
    logic        queue_full2;
    rq_push_t    push;
    dir_out_t    res0;
    dir_out_t    res1;

    // APB: zero-wait, single register at byte address 0
    assign pready  = 1'b1;
    assign cfg_hit = (paddr[PADDR_W-1:2] == REG_ROOT_ENTRY_COUNT);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? {{(PDATA_W-16){1'b0}}, count_reg} : '0;

    always_comb
    begin
        count_next = count_reg;
        if (cfg_wr)
            count_next = pwdata[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= ROOT_COUNT_RESET;
        else
            count_reg <= count_next;
    end

    // an input transaction completes on valid with no stall
    assign in_stall = queue_full2;
    assign in_fire  = in_valid && !in_stall;

    fatdir_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_item    (in_data),
        .root_count (count_reg),
        .push       (push),
        .res0       (res0),
        .res1       (res1)
    );

    fatdir_rqueue #(
        .DEPTH (RQ_DEPTH)
    ) u_rqueue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata0    (res0),
        .wdata1    (res1),
        .full2     (queue_full2),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // a write shows up in the count register on the next cycle
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (count_reg == $past(pwdata[15:0])))
        else $error("root entry count write lost");

    // bytes are only taken while the queue has room for two results
    a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !queue_full2)
        else $error("byte accepted with result queue near full");

    // a result is never offered while nothing was ever queued
    a_out_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(push.push0))
        else $error("output valid without a queued result");

endmodule

/* rtl/fatdir_parser.sv */
// ----------------------------------------------------------------------------
// fatdir_parser
// Byte-wise entry splitter: collects 8.3 fields and emits up to two results
// per accepted byte.
// ----------------------------------------------------------------------------
module fatdir_parser
    import fatdir_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  dir_in_t   in_item,
    input  logic [15:0] root_count,
    output rq_push_t  push,
    output dir_out_t  res0,
    output dir_out_t  res1
);

    // control state
    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [15:0]      seen_reg,   seen_next;
    logic             active_reg, active_next;

    // entry field stores (fully rewritten before use, no reset)
    logic             skip_reg,  skip_next;
    logic [7:0]       attr_reg,  attr_next;
    logic [63:0]      name_reg,  name_next;
    logic [23:0]      ext_reg,   ext_next;
    logic [3:0]       nlen_reg,  nlen_next;
    logic [1:0]       elen_reg,  elen_next;
    logic [15:0]      clus_reg,  clus_next;
    logic [31:0]      size_reg,  size_next;

    logic [7:0]       b;
    logic             start;
    logic [POS_W-1:0] pos_eff;
    logic [15:0]      seen_eff;
    logic [16:0]      seen_inc;
    logic             pad;
    dir_out_t         entry_res;
    logic [1:0]       kind;

    assign b        = in_item.dir_byte;
    assign start    = in_item.region_start;
    assign pos_eff  = start ? POS_FIRST : pos_reg;
    assign seen_eff = start ? 16'd0 : seen_reg;
    assign seen_inc = {1'b0, seen_eff} + 17'd1;
    assign pad      = is_pad(b);

    always_comb
    begin
        case (attr_reg)
            ATTR_DIR:  kind = KIND_DIR;
            ATTR_FILE: kind = KIND_FILE;
            default:   kind = KIND_OTHER;
        endcase
    end

    // Entry result as seen on its last byte
    always_comb
    begin
        entry_res               = '0;
        entry_res.result_status = STATUS_ENTRY;
        entry_res.entry_kind    = kind;
        entry_res.name_bytes    = name_reg;
        entry_res.name_length   = nlen_reg;
        entry_res.ext_bytes     = ext_reg;
        entry_res.ext_length    = elen_reg;
        entry_res.first_cluster = clus_reg;
        entry_res.file_size     = {b, size_reg[23:0]};
        entry_res.entry_number  = seen_eff;
    end

    always_comb
    begin
        pos_next    = pos_reg;
        seen_next   = seen_reg;
        active_next = active_reg;
        skip_next   = skip_reg;
        attr_next   = attr_reg;
        name_next   = name_reg;
        ext_next    = ext_reg;
        nlen_next   = nlen_reg;
        elen_next   = elen_reg;
        clus_next   = clus_reg;
        size_next   = size_reg;
        push        = '0;
        res0        = entry_res;
        res1        = make_end(seen_inc[15:0]);

        if (in_fire)
        begin
            if (start && (root_count == 16'd0))
            begin
                // zero-length region: end right away
                pos_next    = POS_FIRST;
                seen_next   = 16'd0;
                active_next = 1'b0;
                push.push0  = 1'b1;
                res0        = make_end(16'd0);
            end
            else if (start || active_reg)
            begin
                if ((pos_eff == POS_FIRST) && (b == BYTE_END_MARK))
                begin
                    pos_next    = POS_FIRST;
                    seen_next   = seen_eff;
                    active_next = 1'b0;
                    push.push0  = 1'b1;
                    res0        = make_end(seen_eff);
                end
                else
                begin
                    active_next = 1'b1;
                    seen_next   = seen_eff;

                    // field capture by byte lane
                    if (pos_eff == POS_FIRST)
                    begin
                        skip_next = (b == BYTE_DELETED);
                        elen_next = 2'd0;
                        nlen_next = 4'd0;
                    end
                    if (pos_eff < POS_EXT0)
                    begin
                        name_next[8*pos_eff[2:0] +: 8] = b;
                        if (!pad)
                            nlen_next = {1'b0, pos_eff[2:0]} + 4'd1;
                    end
                    else if (pos_eff < POS_ATTR)
                    begin
                        ext_next[8*pos_eff[1:0] +: 8] = b;
                        if (!pad)
                            elen_next = pos_eff[1:0] + 2'd1;
                    end
                    else if (pos_eff == POS_ATTR)
                    begin
                        attr_next = b;
                        if (b == ATTR_LONG_NAME)
                            skip_next = 1'b1;
                    end
                    else if ((pos_eff == POS_CLUS0) || (pos_eff == POS_CLUS1))
                    begin
                        clus_next[8*pos_eff[0] +: 8] = b;
                    end
                    else if (pos_eff >= POS_SIZE0)
                    begin
                        size_next[8*pos_eff[1:0] +: 8] = b;
                    end

                    if (pos_eff == POS_LAST)
                    begin
                        pos_next  = POS_FIRST;
                        seen_next = seen_inc[15:0];
                        if (seen_inc >= {1'b0, root_count})
                            active_next = 1'b0;
                        if (!skip_reg)
                        begin
                            push.push0 = 1'b1;
                            push.push1 = (seen_inc >= {1'b0, root_count});
                        end
                        else if (seen_inc >= {1'b0, root_count})
                        begin
                            push.push0 = 1'b1;
                            res0       = make_end(seen_inc[15:0]);
                        end
                    end
                    else
                    begin
                        pos_next = pos_eff + POS_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= POS_FIRST;
            seen_reg   <= 16'd0;
            active_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            seen_reg   <= seen_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skip_reg <= skip_next;
        attr_reg <= attr_next;
        name_reg <= name_next;
        ext_reg  <= ext_next;
        nlen_reg <= nlen_next;
        elen_reg <= elen_next;
        clus_reg <= clus_next;
        size_reg <= size_next;
    end

    // mid-entry position only while a scan runs
    a_pos_active: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != POS_FIRST) |-> active_reg)
        else $error("byte position advanced with no active scan");

    // a second result in one step is always the end of scan
    a_second_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        push.push1 |-> (push.push0 && (res1.result_status == STATUS_END)))
        else $error("second result is not an end result");

    // after an end result the scan is idle
    a_end_idles: assert property (@(posedge clk) disable iff (!rst_n)
        ((push.push0 && (res0.result_status == STATUS_END)) || push.push1)
        |=> !active_reg)
        else $error("scan still active after end result");

endmodule

/* rtl/fatdir_rqueue.sv */
// ----------------------------------------------------------------------------
// fatdir_rqueue
// Small result queue: up to two writes and, while out_stall is low, one read per cycle.
// ----------------------------------------------------------------------------
module fatdir_rqueue
    import fatdir_pkg::*;
#(
    parameter int unsigned DEPTH = RQ_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  rq_push_t push,
    input  dir_out_t wdata0,
    input  dir_out_t wdata1,
    output logic     full2,
    output logic     out_valid,
    input  logic     out_stall,
    output dir_out_t out_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

    dir_out_t         slot_reg [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next;
    logic [AW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [AW-1:0]    wr_p1;
    logic             pop;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    assign wr_p1     = ptr_inc(wr_reg);
    assign out_valid = (cnt_reg != '0);
    assign out_data  = slot_reg[rd_reg];
    assign pop       = out_valid && !out_stall;
    assign full2     = (cnt_reg > ROOM_LIMIT);

    always_comb
    begin
        wr_next = wr_reg;
        if (push.push1)
            wr_next = ptr_inc(wr_p1);
        else if (push.push0)
            wr_next = wr_p1;
        rd_next  = pop ? ptr_inc(rd_reg) : rd_reg;
        cnt_next = cnt_reg + CW'(push.push0) + CW'(push.push1) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
            slot_reg[wr_reg] <= wdata0;
        if (push.push1)
            slot_reg[wr_p1] <= wdata1;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.push0 |-> (cnt_reg <= ROOM_LIMIT))
        else $error("push into queue without room for two");

endmodule
